### rtl/core/bce_pkg.sv
// ----------------------------------------------------------------------------
// Bitwise convolution engine package
// Shared constants and command/mode codes for the convolution engine.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int LogMax   = 10;
    localparam int DataBits = 16;
    localparam int WordBits = 64;
    localparam int OutBits  = 42;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_COMPUTE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] MODE_XOR = 2'd0;
    localparam logic [1:0] MODE_AND = 2'd1;
    localparam logic [1:0] MODE_OR  = 2'd2;

    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_LOG_SIZE = 1'b1;

endpackage

### rtl/core/bce_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/bitwise_convolution_engine_core.sv
// ----------------------------------------------------------------------------
// Bitwise convolution engine
// XOR/AND/OR convolution of two loaded sequences by fast Walsh-Hadamard
// style butterfly transforms held in two on-chip memories.
// ----------------------------------------------------------------------------
// Usage: configure mode and log_size through the config channel. It is ready
// only while the sequencer is idle. Input beats carry a command. A load writes
// a sign-extended pair at an index (complemented in OR mode) and gives no
// output beat. It completes at acceptance, so loads stream one per cycle while
// the sequencer is idle and the output register holds no stalled beat.
// A read drives the memory address at acceptance, waits in the read state for
// the registered data, and its beat (is_done clear) then enters the output
// register. A new command is taken only once the sequencer is back in idle.
// A compute runs three transforms: forward on both memories, then inverse on
// the first. Each butterfly reads both entries, captures them and writes both
// back through the single ports. For each entry the product sweep forms the
// low 64 bits of the product from three 32x32 partial products. In XOR mode
// each entry is then shifted right by k. At log_size zero only the sweep runs.
// Then one beat with is_done set follows. Reset clears the control state only.
// The memories keep their contents, and every entry must be loaded before
// use. When the receiver stalls, the finished beat waits in the output
// register. The block takes no further command until that beat is taken.
// ----------------------------------------------------------------------------
module bitwise_convolution_engine_core #(
    parameter int LOG_MAX   = bce_pkg::LogMax,
    parameter int DATA_BITS = bce_pkg::DataBits
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_cmd,
    input  logic [LOG_MAX-1:0]                 i_index,
    input  logic signed [DATA_BITS-1:0]        i_a_value,
    input  logic signed [DATA_BITS-1:0]        i_b_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [bce_pkg::OutBits-1:0] o_result_value,
    output logic                               o_is_done,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [3:0]                         i_cfg_data
);
    localparam int AW    = LOG_MAX;
    localparam int DEPTH = 1 << LOG_MAX;
    localparam int KW    = $clog2(LOG_MAX + 1);
    localparam int W     = bce_pkg::WordBits;
    localparam int HW    = W / 2;
    localparam int OB    = bce_pkg::OutBits;

    // Transform pass codes.
    localparam logic [1:0] PASS_FWD_A = 2'd0;
    localparam logic [1:0] PASS_FWD_B = 2'd1;
    localparam logic [1:0] PASS_INV   = 2'd2;

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_RD0  = 15'b000000000000010,  // issue read of lower entry
        S_RD1  = 15'b000000000000100,  // issue read of upper entry
        S_WR0  = 15'b000000000001000,  // upper data arrives
        S_WR1  = 15'b000000000010000,  // write lower entry
        S_WR2  = 15'b000000000100000,  // write upper entry
        S_MUL0 = 15'b000000001000000,  // read both memories at product index
        S_MUL1 = 15'b000000010000000,  // capture operands
        S_MUL2 = 15'b000000100000000,  // low by low partial product
        S_MUL3 = 15'b000001000000000,  // high by low partial product
        S_MUL4 = 15'b000010000000000,  // low by high partial product
        S_MUL5 = 15'b000100000000000,  // write product
        S_SH0  = 15'b001000000000000,  // XOR scale read
        S_SH1  = 15'b010000000000000,  // XOR scale write
        S_READ = 15'b100000000000000   // read data arrives
    } t_state;

    t_state r_state, n_state;

    logic [1:0]    r_mode;
    logic [3:0]    r_log_size;
    logic [KW-1:0] w_k;
    logic [AW:0]   w_n;
    logic [AW:0]   w_half;
    logic [AW-1:0] w_mask;

    logic [1:0]    r_pass;
    logic [KW-1:0] r_lvl;      // butterfly level, stride = 1 << lvl
    logic [AW-1:0] r_bf;       // butterfly counter within level (n/2)
    logic [AW-1:0] r_idx;      // sweep counter for product and scaling
    logic [W-1:0]  r_u, r_v;
    logic [W-1:0]  r_acc;
    logic          r_out_done;
    logic [OB-1:0] r_out_val;
    logic          r_out_valid;

    assign w_k    = (int'(r_log_size) > LOG_MAX) ? KW'(LOG_MAX) : KW'(r_log_size);
    assign w_n    = (AW+1)'(1) << w_k;
    assign w_half = w_n >> 1;
    assign w_mask = w_n[AW-1:0] - AW'(1);

    // Butterfly addresses: insert a zero at bit lvl of the counter.
    logic [AW-1:0] w_bf, w_low_mask, w_lo_addr, w_hi_addr, w_stride;
    assign w_bf       = r_bf;
    assign w_stride   = AW'(1) << r_lvl;
    assign w_low_mask = w_stride - AW'(1);
    assign w_lo_addr  = ((w_bf & ~w_low_mask) << 1) | (w_bf & w_low_mask);
    assign w_hi_addr  = w_lo_addr | w_stride;

    logic [AW-1:0] w_in_idx;
    assign w_in_idx = (r_mode == bce_pkg::MODE_OR) ? (~i_index & w_mask)
                                                  : (i_index & w_mask);

    // Memory ports.
    logic          a_we, b_we;
    logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
    logic [W-1:0]  a_wdata, b_wdata, a_rdata, b_rdata;

    bce_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata));
    bce_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(b_raddr), .o_rdata(b_rdata));

    logic          w_accept;
    logic          w_on_b;
    logic          w_finish;
    logic [W-1:0]  w_rd, w_lo_new, w_hi_new;
    logic [W-1:0]  w_ext_a, w_ext_b;
    logic [HW-1:0] w_mul_x, w_mul_y;
    logic [W-1:0]  w_mul_p;

    // A new command may enter while the output register hands off its beat.
    assign o_ready     = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_on_b      = (r_pass == PASS_FWD_B);
    assign w_rd        = w_on_b ? b_rdata : a_rdata;

    assign w_ext_a = W'(i_a_value);
    assign w_ext_b = W'(i_b_value);

    // One 32x32 multiplier, reused for the three partial products that
    // make up the low 64 bits of the product.
    assign w_mul_p = W'(w_mul_x) * W'(w_mul_y);

    always_comb begin
        if (r_mode == bce_pkg::MODE_XOR) begin
            w_lo_new = r_u + r_v;
            w_hi_new = r_u - r_v;
        end else if (r_pass == PASS_INV) begin
            w_lo_new = r_u - r_v;
            w_hi_new = r_v;
        end else begin
            w_lo_new = r_u + r_v;
            w_hi_new = r_v;
        end
    end

    logic w_last_bf, w_last_lvl, w_last_idx;
    assign w_last_bf  = (r_bf == w_half[AW-1:0] - AW'(1));
    assign w_last_lvl = (r_lvl == w_k - KW'(1));
    assign w_last_idx = (r_idx == w_mask);

    always_comb begin
        n_state  = r_state;
        w_finish = 1'b0;
        a_we = 1'b0; b_we = 1'b0;
        a_waddr = w_lo_addr; b_waddr = w_lo_addr;
        a_wdata = w_lo_new;  b_wdata = w_lo_new;
        a_raddr = w_lo_addr; b_raddr = w_lo_addr;
        w_mul_x = r_u[HW-1:0];
        w_mul_y = r_v[HW-1:0];
        case (r_state)
            S_IDLE: begin
                a_raddr = w_in_idx;
                a_waddr = w_in_idx; b_waddr = w_in_idx;
                a_wdata = w_ext_a;  b_wdata = w_ext_b;
                if (w_accept) begin
                    case (i_cmd)
                        bce_pkg::CMD_LOAD: begin
                            a_we = 1'b1; b_we = 1'b1;
                        end
                        bce_pkg::CMD_COMPUTE: begin
                            n_state = (w_k == '0) ? S_MUL0 : S_RD0;
                        end
                        bce_pkg::CMD_READ: begin
                            n_state = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD0: begin
                n_state = S_RD1;
            end
            S_RD1: begin
                a_raddr = w_hi_addr; b_raddr = w_hi_addr;
                n_state = S_WR0;
            end
            S_WR0: begin
                n_state = S_WR1;
            end
            S_WR1: begin
                a_we = !w_on_b; b_we = w_on_b;
                n_state = S_WR2;
            end
            S_WR2: begin
                a_we = !w_on_b; b_we = w_on_b;
                a_waddr = w_hi_addr; b_waddr = w_hi_addr;
                a_wdata = w_hi_new;  b_wdata = w_hi_new;
                if (!w_last_bf || !w_last_lvl || r_pass == PASS_FWD_A) begin
                    n_state = S_RD0;
                end else if (r_pass == PASS_FWD_B) begin
                    n_state = S_MUL0;
                end else if (r_mode == bce_pkg::MODE_XOR) begin
                    n_state = S_SH0;
                end else begin
                    n_state  = S_IDLE;
                    w_finish = 1'b1;
                end
            end
            S_MUL0: begin
                a_raddr = r_idx; b_raddr = r_idx;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_MUL3;
            end
            S_MUL3: begin
                w_mul_x = r_u[W-1:HW];
                n_state = S_MUL4;
            end
            S_MUL4: begin
                w_mul_y = r_v[W-1:HW];
                n_state = S_MUL5;
            end
            S_MUL5: begin
                a_we = 1'b1; a_waddr = r_idx; a_wdata = r_acc;
                if (!w_last_idx) begin
                    n_state = S_MUL0;
                end else if (w_k == '0) begin
                    // A single entry needs no inverse transform and no scaling.
                    n_state  = S_IDLE;
                    w_finish = 1'b1;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_SH0: begin
                a_raddr = r_idx;
                n_state = S_SH1;
            end
            S_SH1: begin
                a_we = 1'b1; a_waddr = r_idx;
                a_wdata = $signed(a_rdata) >>> w_k;
                if (w_last_idx) begin
                    n_state  = S_IDLE;
                    w_finish = 1'b1;
                end else begin
                    n_state = S_SH0;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= bce_pkg::MODE_XOR;
            r_log_size  <= 4'd10;
            r_out_valid <= 1'b0;
            r_pass      <= PASS_FWD_A;
            r_lvl       <= '0;
            r_bf        <= '0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    bce_pkg::REG_MODE:     r_mode     <= i_cfg_data[1:0];
                    bce_pkg::REG_LOG_SIZE: r_log_size <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_READ || w_finish) begin
                r_out_valid <= 1'b1;
                r_out_done  <= w_finish;
                r_out_val   <= w_finish ? '0 : a_rdata[OB-1:0];
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_cmd == bce_pkg::CMD_COMPUTE) begin
                        r_pass <= PASS_FWD_A;
                        r_lvl  <= '0;
                        r_bf   <= '0;
                        r_idx  <= '0;
                    end
                end
                S_RD1: begin
                    r_u <= w_rd;
                end
                S_WR0: begin
                    r_v <= w_rd;
                end
                S_WR2: begin
                    if (!w_last_bf) begin
                        r_bf <= r_bf + AW'(1);
                    end else begin
                        r_bf <= '0;
                        if (!w_last_lvl) begin
                            r_lvl <= r_lvl + KW'(1);
                        end else begin
                            r_lvl  <= '0;
                            r_pass <= r_pass + 2'd1;
                        end
                    end
                end
                S_MUL1: begin
                    r_u <= a_rdata;
                    r_v <= b_rdata;
                end
                S_MUL2: begin
                    r_acc <= w_mul_p;
                end
                S_MUL3, S_MUL4: begin
                    r_acc[W-1:HW] <= r_acc[W-1:HW] + w_mul_p[HW-1:0];
                end
                S_MUL5, S_SH1: begin
                    r_idx <= w_last_idx ? '0 : r_idx + AW'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_val;
    assign o_is_done      = r_out_done;
endmodule
